### rtl/dual_stack_shared_memory_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual stack block
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_STACK_SHARED_MEMORY_TOP_ASSERT_SVH
`define DUAL_STACK_SHARED_MEMORY_TOP_ASSERT_SVH
`ifndef SYNTH
`define DSSM_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("dssm assertion failed");
`define DSSM_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dssm assertion failed");
`else
`define DSSM_ASSERT_NEVER(lbl, cond)
`define DSSM_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

### rtl/dssm_pkg.sv
// ----------------------------------------------------------------------------
// dssm_pkg
// Shared constants, word types and codes of the dual stack block.
// ----------------------------------------------------------------------------
package dssm_pkg;

	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int VALUE_W     = 32;
	localparam int CNT_W       = 7;
	localparam int CFG_IDX_W   = 1;
	localparam int OPQ_DEPTH   = 2;
	localparam int OPQ_PTR_W   = 1;
	localparam int OPQ_CNT_W   = 2;
	localparam int OUTQ_DEPTH  = 4;
	localparam int OUTQ_PTR_W  = 2;
	localparam int OUTQ_CNT_W  = 3;

	localparam logic [CNT_W-1:0] CAP_RESET = 7'd32;

	localparam logic [CFG_IDX_W-1:0] REG_CAP_NONNEG = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CAP_NEG    = 1'b1;

	localparam logic [2:0] CMD_PUSH         = 3'd0;
	localparam logic [2:0] CMD_POP_NONNEG   = 3'd1;
	localparam logic [2:0] CMD_POP_NEG      = 3'd2;
	localparam logic [2:0] CMD_PRINT_NONNEG = 3'd3;
	localparam logic [2:0] CMD_PRINT_NEG    = 3'd4;

	localparam logic [1:0] STAT_DATA     = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW = 2'd1;
	localparam logic [1:0] STAT_EMPTY    = 2'd2;

	typedef struct packed {
		logic [2:0]                cmd;
		logic signed [VALUE_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] data;
		logic [1:0]                status;
		logic                      last;
	} result_t;

	typedef enum logic [2:0] {
		OP_PUSH_NN,
		OP_PUSH_NG,
		OP_POP_NN,
		OP_POP_NG,
		OP_PRINT_NN,
		OP_PRINT_NG
	} op_kind_t;

	typedef struct packed {
		op_kind_t           kind;
		logic [VALUE_W-1:0] value;
	} op_t;

	typedef struct packed {
		logic s1_valid;
		logic printing;
	} back_stat_t;

	typedef struct packed {
		logic [OUTQ_CNT_W-1:0] count;
	} outq_stat_t;

endpackage

### rtl/dssm_ram.sv
// ----------------------------------------------------------------------------
// dssm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module dssm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/dssm_front.sv
// ----------------------------------------------------------------------------
// dssm_front
// Takes input words, decodes them into stack operations and queues them.
// ----------------------------------------------------------------------------
module dssm_front import dssm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t item,
	output logic  full,
	output logic  op_valid,
	output op_t   op,
	input  logic  op_take
);

	op_t                  opq_q [OPQ_DEPTH];
	logic [OPQ_PTR_W-1:0] wr_ptr_q;
	logic [OPQ_PTR_W-1:0] rd_ptr_q;
	logic [OPQ_CNT_W-1:0] cnt_q;
	op_t                  new_op;
	logic                 known;
	logic                 enq;
	logic                 deq;

	always_comb begin
		new_op.value = item.value;
		new_op.kind  = OP_PUSH_NN;
		known        = 1'b1;
		case (item.cmd)
			CMD_PUSH: begin
				new_op.kind = item.value[VALUE_W-1] ? OP_PUSH_NG : OP_PUSH_NN;
			end
			CMD_POP_NONNEG:   new_op.kind = OP_POP_NN;
			CMD_POP_NEG:      new_op.kind = OP_POP_NG;
			CMD_PRINT_NONNEG: new_op.kind = OP_PRINT_NN;
			CMD_PRINT_NEG:    new_op.kind = OP_PRINT_NG;
			default:          known = 1'b0;
		endcase
	end

	assign full     = (cnt_q == OPQ_CNT_W'(OPQ_DEPTH));
	assign op_valid = (cnt_q != '0);
	assign op       = opq_q[rd_ptr_q];
	assign enq      = push && !full && known;
	assign deq      = op_valid && op_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + OPQ_CNT_W'(enq) - OPQ_CNT_W'(deq);
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			opq_q[wr_ptr_q] <= new_op;
		end
	end

endmodule

### rtl/dssm_back.sv
// ----------------------------------------------------------------------------
// dssm_back
// Executes stack operations on the shared store and issues result words.
// ----------------------------------------------------------------------------
module dssm_back import dssm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_wdata,
	input  logic                 op_valid,
	input  op_t                  op,
	output logic                 op_take,
	input  outq_stat_t           outq_stat,
	output logic                 res_valid,
	output result_t              res,
	output back_stat_t           stat
);

	typedef enum logic {ST_IDLE, ST_PRINT} state_t;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cap_nn_q, cap_ng_q;
	logic [CNT_W-1:0]   cnt_nn_q, cnt_nn_d;
	logic [CNT_W-1:0]   cnt_ng_q, cnt_ng_d;
	logic [CNT_W-1:0]   idx_q, idx_d;
	logic [CNT_W-1:0]   base_q, base_d;
	logic               valid_s1;
	logic               ram_s1;
	logic [VALUE_W-1:0] const_s1;
	logic [1:0]         status_s1;
	logic               last_s1;

	logic [CNT_W-1:0]   cn, room, cg;
	logic               can_issue;
	logic               iss_valid, iss_ram, iss_last;
	logic [VALUE_W-1:0] iss_const;
	logic [1:0]         iss_status;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
	logic [VALUE_W-1:0] ram_rdata;

	assign cn   = (cap_nn_q > CNT_W'(STORE_DEPTH)) ? CNT_W'(STORE_DEPTH) : cap_nn_q;
	assign room = CNT_W'(STORE_DEPTH) - cn;
	assign cg   = (cap_ng_q > room) ? room : cap_ng_q;

	assign can_issue = ({1'b0, outq_stat.count} + (OUTQ_CNT_W+1)'(valid_s1))
		< (OUTQ_CNT_W+1)'(OUTQ_DEPTH);

	always_comb begin
		state_d    = state_q;
		cnt_nn_d   = cnt_nn_q;
		cnt_ng_d   = cnt_ng_q;
		idx_d      = idx_q;
		base_d     = base_q;
		op_take    = 1'b0;
		iss_valid  = 1'b0;
		iss_ram    = 1'b0;
		iss_const  = '1;
		iss_status = STAT_DATA;
		iss_last   = 1'b1;
		ram_we     = 1'b0;
		ram_waddr  = ADDR_W'(cnt_nn_q);
		ram_raddr  = ADDR_W'(base_q + idx_q - 1'b1);
		case (state_q)
			ST_IDLE: begin
				if (op_valid && can_issue) begin
					op_take = 1'b1;
					case (op.kind)
						OP_PUSH_NN: begin
							if (cnt_nn_q >= cn) begin
								iss_valid  = 1'b1;
								iss_status = STAT_OVERFLOW;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = ADDR_W'(cnt_nn_q);
								cnt_nn_d  = cnt_nn_q + 1'b1;
							end
						end
						OP_PUSH_NG: begin
							if (cnt_ng_q >= cg) begin
								iss_valid  = 1'b1;
								iss_status = STAT_OVERFLOW;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = ADDR_W'(cn + cnt_ng_q);
								cnt_ng_d  = cnt_ng_q + 1'b1;
							end
						end
						OP_POP_NN: begin
							iss_valid = 1'b1;
							if (cnt_nn_q == '0) begin
								iss_status = STAT_EMPTY;
							end else begin
								iss_ram   = 1'b1;
								ram_raddr = ADDR_W'(cnt_nn_q - 1'b1);
								cnt_nn_d  = cnt_nn_q - 1'b1;
							end
						end
						OP_POP_NG: begin
							iss_valid = 1'b1;
							iss_const = '0;
							if (cnt_ng_q == '0) begin
								iss_status = STAT_EMPTY;
							end else begin
								iss_ram   = 1'b1;
								ram_raddr = ADDR_W'(cn + cnt_ng_q - 1'b1);
								cnt_ng_d  = cnt_ng_q - 1'b1;
							end
						end
						OP_PRINT_NN: begin
							if (cnt_nn_q != '0) begin
								state_d = ST_PRINT;
								idx_d   = cnt_nn_q;
								base_d  = '0;
							end
						end
						OP_PRINT_NG: begin
							if (cnt_ng_q != '0) begin
								state_d = ST_PRINT;
								idx_d   = cnt_ng_q;
								base_d  = cn;
							end
						end
						default: ;
					endcase
				end
			end
			ST_PRINT: begin
				if (can_issue) begin
					iss_valid = 1'b1;
					iss_ram   = 1'b1;
					iss_last  = (idx_q == CNT_W'(1));
					idx_d     = idx_q - 1'b1;
					if (idx_q == CNT_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
		// register write empties both stacks
		if (cfg_we) begin
			cnt_nn_d = '0;
			cnt_ng_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cap_nn_q <= CAP_RESET;
			cap_ng_q <= CAP_RESET;
			cnt_nn_q <= '0;
			cnt_ng_q <= '0;
			idx_q    <= '0;
			base_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_nn_q <= cnt_nn_d;
			cnt_ng_q <= cnt_ng_d;
			idx_q    <= idx_d;
			base_q   <= base_d;
			valid_s1 <= iss_valid;
			if (cfg_we) begin
				case (cfg_index)
					REG_CAP_NONNEG: cap_nn_q <= cfg_wdata;
					REG_CAP_NEG:    cap_ng_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		ram_s1    <= iss_ram;
		const_s1  <= iss_const;
		status_s1 <= iss_status;
		last_s1   <= iss_last;
	end

	dssm_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (op.value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign res_valid     = valid_s1;
	assign res.data      = ram_s1 ? ram_rdata : const_s1;
	assign res.status    = status_s1;
	assign res.last      = last_s1;
	assign stat.s1_valid = valid_s1;
	assign stat.printing = (state_q == ST_PRINT);

endmodule

### rtl/dssm_outq.sv
// ----------------------------------------------------------------------------
// dssm_outq
// Result queue between the execution side and the result port.
// ----------------------------------------------------------------------------
module dssm_outq import dssm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  result_t    wr_data,
	output logic       empty,
	input  logic       pop,
	output result_t    rd_data,
	output outq_stat_t stat
);

	result_t               buf_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wr_ptr_q;
	logic [OUTQ_PTR_W-1:0] rd_ptr_q;
	logic [OUTQ_CNT_W-1:0] cnt_q;
	logic                  deq;

	assign empty      = (cnt_q == '0);
	assign rd_data    = buf_q[rd_ptr_q];
	assign deq        = pop && !empty;
	assign stat.count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + OUTQ_CNT_W'(wr_en) - OUTQ_CNT_W'(deq);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### rtl/dual_stack_shared_memory_top.sv
// ----------------------------------------------------------------------------
// Dual stack in a shared store
// Two LIFO stacks in one 64-word store: non-negative values grow up from
// entry 0, negative values grow up from the effective non-negative capacity.
// Commands enter a two-word queue and the execution side takes one per
// cycle while it is idle and the result queue has room: a push or a pop
// uses the store's single write and read port, and a print starts and then
// reads each stored entry in turn. A command's result words are registered
// in the issue stage and then queued for the result port. A full push and
// an empty pop each give one flagged word; a good push and an empty print
// give none. Writing either capacity register empties both stacks; write
// only while idle.
// ----------------------------------------------------------------------------
`include "dual_stack_shared_memory_top_assert.svh"

module dual_stack_shared_memory_top import dssm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  item_t                item,
	output logic                 full,
	output logic                 empty,
	input  logic                 pop,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_wdata
);

	logic       op_valid;
	op_t        op;
	logic       op_take;
	logic       res_valid;
	result_t    res;
	back_stat_t back_stat;
	outq_stat_t outq_stat;

	dssm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.op_valid (op_valid),
		.op       (op),
		.op_take  (op_take)
	);

	dssm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.op_valid  (op_valid),
		.op        (op),
		.op_take   (op_take),
		.outq_stat (outq_stat),
		.res_valid (res_valid),
		.res       (res),
		.stat      (back_stat)
	);

	dssm_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res),
		.empty   (empty),
		.pop     (pop),
		.rd_data (result),
		.stat    (outq_stat)
	);

	// result queue never overruns; an in-flight result word always has a slot
	`DSSM_ASSERT_NEVER(a_outq_bound, outq_stat.count > OUTQ_CNT_W'(OUTQ_DEPTH))
	`DSSM_ASSERT_IMPLY(a_issue_room, back_stat.s1_valid, outq_stat.count < OUTQ_CNT_W'(OUTQ_DEPTH))

endmodule
